// ----- hw/rtl/tcdr_pkg.sv -----
package tcdr_pkg;

	// Fixed store geometry.
	localparam int FONT_WORDS         = 256;
	localparam int FONT_AW            = 8;
	localparam int PAL_WORDS          = 16;
	localparam int PAL_AW             = 4;
	localparam int COLOR_W            = 12;
	localparam int RGB_W              = 24;
	localparam int GLYPH_W            = 32;
	localparam int TILE_W             = GLYPH_W + 2 * COLOR_W;
	localparam int CELL_COUNT_DEFAULT = 384;

	// Power-on palette, 0x0RGB per entry.
	localparam logic [COLOR_W-1:0] DEFAULT_PALETTE [PAL_WORDS] = '{
		12'h000, 12'h00a, 12'h0a0, 12'h0aa, 12'ha00, 12'ha0a, 12'ha50, 12'haaa,
		12'h555, 12'h55f, 12'h5f5, 12'h5ff, 12'hf55, 12'hf5f, 12'hff5, 12'hfff
	};

	typedef enum logic [2:0] {
		OP_LOAD_FONT = 3'd0,
		OP_LOAD_PAL  = 3'd1,
		OP_RENDER    = 3'd2,
		OP_BLINK     = 3'd3,
		OP_BORDER    = 3'd4
	} tcdr_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT,
		ST_BORDER
	} tcdr_state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [8:0]  index;
		logic [15:0] data;
	} tcdr_cmd_t;

	typedef struct packed {
		logic       changed;
		logic [1:0] pixel_x;
		logic [2:0] pixel_y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} tcdr_res_t;

	// Widens a 12-bit palette color to 24 bits by repeating each nibble.
	function automatic logic [RGB_W-1:0] expand_color(logic [COLOR_W-1:0] c);
		return {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
	endfunction

endpackage

// ----- hw/rtl/tcdr_tile_cache.sv -----
module tcdr_tile_cache #(
	parameter int CELL_COUNT = tcdr_pkg::CELL_COUNT_DEFAULT,
	parameter int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [CELL_AW-1:0]          rd_addr,
	output logic [tcdr_pkg::TILE_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [CELL_AW-1:0]          wr_addr,
	input  logic [tcdr_pkg::TILE_W-1:0] wr_data,
	output logic                        clearing
);
	import tcdr_pkg::*;

	localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELL_COUNT - 1);

	logic [TILE_W-1:0]  mem [CELL_COUNT];
	logic               clearing_q;
	logic [CELL_AW-1:0] clr_cnt_q;
	logic               mem_we;
	logic [CELL_AW-1:0] mem_wa;
	logic [TILE_W-1:0]  mem_wd;

	// After reset every entry is swept to zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST_CELL) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		mem_we = clearing_q || wr_en;
		mem_wa = clearing_q ? clr_cnt_q : wr_addr;
		mem_wd = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule

// ----- hw/rtl/text_cell_display_renderer_top.sv -----
// Text cell display renderer.
//
// Commands enter on cmd and are taken at a rising edge where start is high and
// busy is low. Font and palette loads and the blink tick complete in the cycle
// they are taken and produce nothing. A render request for a cell below
// CELL_COUNT reads the font, the palette and the cell's tile cache entry,
// compares the new tile in the next cycle (ST_LOOKUP), and then either emits
// one "unchanged" result or 32 pixel results on consecutive cycles (x 0..3
// outer, y 7..0 inner); a render for any other cell produces nothing. A
// border refresh produces one result through ST_BORDER and the result
// register, as an unchanged result goes through ST_LOOKUP and the result
// register; the first pixel comes in the cycle after that, through ST_EMIT.
// Busy stays high until the last result of a render or border request is on
// the ports. Results are shown for exactly one cycle, marked by result_strobe;
// the receiver cannot stall them. The border color index is written on the
// cfg channel (cfg_ready is always high) and should only change while the block is idle.
// After reset the palette reads as the default palette, blink phase and the
// border cache are zero, and the tile cache is swept to zero while busy stays
// high. The font store is undefined until loaded.
module text_cell_display_renderer_top #(
	parameter int CELL_COUNT = tcdr_pkg::CELL_COUNT_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tcdr_pkg::tcdr_cmd_t cmd,
	output logic                result_strobe,
	output tcdr_pkg::tcdr_res_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data
);
	import tcdr_pkg::*;

	localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	// Control state.
	tcdr_state_t state_q, state_d;
	logic        blink_q;
	logic [3:0]  border_idx_q;
	logic [23:0] border_q;
	logic [4:0]  k_q;
	logic        strobe_q;

	// The font store has no reset; the palette store has one valid bit per
	// entry, and an entry never written reads as the default palette.
	logic [15:0]          font_mem [FONT_WORDS];
	logic [COLOR_W-1:0]   pal_mem  [PAL_WORDS];
	logic [PAL_WORDS-1:0] pal_vld_q;

	// Values read at request time, used in the lookup or border state.
	logic [15:0]        font_hi_s1, font_lo_s1;
	logic [COLOR_W-1:0] pal_a_s1, pal_b_s1;
	logic [PAL_AW-1:0]  pal_addr_a_s1, pal_addr_b_s1;
	logic               pal_hit_a_s1, pal_hit_b_s1;
	logic               blank_s1;
	logic [CELL_AW-1:0] cell_s1;

	// Emission registers.
	logic [GLYPH_W-1:0] glyph_q;
	logic [RGB_W-1:0]   fg_rgb_q, bg_rgb_q;
	tcdr_res_t          result_q;

	logic               accept;
	logic               clearing;
	logic [TILE_W-1:0]  cache_rd;
	logic               cache_we;
	logic               cache_rd_en;

	logic [FONT_AW-1:0] font_addr_hi, font_addr_lo;
	logic [PAL_AW-1:0]  pal_addr_a;
	logic [COLOR_W-1:0] fg_col, bg_col;
	logic [GLYPH_W-1:0] glyph;
	logic [TILE_W-1:0]  tile;
	logic [RGB_W-1:0]   border_col;
	logic               border_we;
	logic               cell_ok;
	tcdr_res_t          res_d;
	logic               res_vld_d;

	assign busy      = clearing || (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign cell_ok      = 32'(cmd.index) < CELL_COUNT;
	assign cache_rd_en  = accept && (cmd.opcode == OP_RENDER) && cell_ok;
	assign font_addr_hi = {cmd.data[6:0], 1'b0};
	assign font_addr_lo = {cmd.data[6:0], 1'b1};
	// Port A serves the foreground color or, for a border refresh, the border.
	assign pal_addr_a   = (cmd.opcode == OP_BORDER) ? border_idx_q : cmd.data[15:12];

	tcdr_tile_cache #(
		.CELL_COUNT (CELL_COUNT),
		.CELL_AW    (CELL_AW)
	) u_cache (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (cache_rd_en),
		.rd_addr  (CELL_AW'(cmd.index)),
		.rd_data  (cache_rd),
		.wr_en    (cache_we),
		.wr_addr  (cell_s1),
		.wr_data  (tile),
		.clearing (clearing)
	);

	// Font and palette stores: written by load requests, read for render and
	// border requests. Loads finish in their accept cycle, so the next request
	// always reads the updated contents.
	always_ff @(posedge clk) begin
		if (accept && (cmd.opcode == OP_LOAD_FONT) && (cmd.index[8] == 1'b0)) begin
			font_mem[cmd.index[FONT_AW-1:0]] <= cmd.data;
		end
		if (accept && (cmd.opcode == OP_LOAD_PAL) && (cmd.index[8:4] == '0)) begin
			pal_mem[cmd.index[PAL_AW-1:0]] <= cmd.data[COLOR_W-1:0];
		end
		if (accept) begin
			font_hi_s1    <= font_mem[font_addr_hi];
			font_lo_s1    <= font_mem[font_addr_lo];
			pal_a_s1      <= pal_mem[pal_addr_a];
			pal_b_s1      <= pal_mem[cmd.data[11:8]];
			pal_addr_a_s1 <= pal_addr_a;
			pal_addr_b_s1 <= cmd.data[11:8];
			pal_hit_a_s1  <= pal_vld_q[pal_addr_a];
			pal_hit_b_s1  <= pal_vld_q[cmd.data[11:8]];
			// A blinking cell is blank while the blink phase is low.
			blank_s1      <= cmd.data[7] && !blink_q;
			cell_s1       <= CELL_AW'(cmd.index);
		end
	end

	// Palette colors as seen after the valid-bit check.
	assign fg_col     = pal_hit_a_s1 ? pal_a_s1 : DEFAULT_PALETTE[pal_addr_a_s1];
	assign bg_col     = pal_hit_b_s1 ? pal_b_s1 : DEFAULT_PALETTE[pal_addr_b_s1];
	assign glyph      = blank_s1 ? '0 : {font_hi_s1, font_lo_s1};
	assign tile       = {glyph, fg_col, bg_col};
	assign border_col = expand_color(fg_col);

	// Next state and result selection.
	always_comb begin
		state_d   = state_q;
		cache_we  = 1'b0;
		border_we = 1'b0;
		res_vld_d = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.opcode == OP_RENDER) && cell_ok) begin
					state_d = ST_LOOKUP;
				end else if (accept && (cmd.opcode == OP_BORDER)) begin
					state_d = ST_BORDER;
				end
			end
			ST_LOOKUP: begin
				res_d.last = 1'b1;
				if (tile != cache_rd) begin
					cache_we = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					res_vld_d = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_EMIT: begin
				res_vld_d     = 1'b1;
				res_d.changed = 1'b1;
				res_d.pixel_x = k_q[4:3];
				res_d.pixel_y = ~k_q[2:0];
				{res_d.red, res_d.green, res_d.blue} = glyph_q[GLYPH_W-1] ? fg_rgb_q : bg_rgb_q;
				res_d.last    = (k_q == 5'd31);
				if (k_q == 5'd31) begin
					state_d = ST_IDLE;
				end
			end
			ST_BORDER: begin
				res_vld_d  = 1'b1;
				res_d.last = 1'b1;
				if (border_col != border_q) begin
					border_we     = 1'b1;
					res_d.changed = 1'b1;
					{res_d.red, res_d.green, res_d.blue} = border_col;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			blink_q      <= 1'b0;
			border_idx_q <= '0;
			border_q     <= '0;
			pal_vld_q    <= '0;
			strobe_q     <= 1'b0;
			k_q          <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= res_vld_d;
			if (cfg_valid && cfg_ready) begin
				border_idx_q <= cfg_data;
			end
			if (accept && (cmd.opcode == OP_BLINK)) begin
				blink_q <= !blink_q;
			end
			if (accept && (cmd.opcode == OP_LOAD_PAL) && (cmd.index[8:4] == '0)) begin
				pal_vld_q[cmd.index[PAL_AW-1:0]] <= 1'b1;
			end
			if (border_we) begin
				border_q <= border_col;
			end
			if (state_q == ST_LOOKUP) begin
				k_q <= '0;
			end else if (state_q == ST_EMIT) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Pixel data path: the glyph shifts out most significant bit first.
	always_ff @(posedge clk) begin
		result_q <= res_d;
		if (state_q == ST_LOOKUP) begin
			glyph_q  <= glyph;
			fg_rgb_q <= expand_color(fg_col);
			bg_rgb_q <= expand_color(bg_col);
		end else if (state_q == ST_EMIT) begin
			glyph_q <= {glyph_q[GLYPH_W-2:0], 1'b0};
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

	// A pixel run, once started, continues without gaps up to its last pixel.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |=> result_strobe)
		else $error("pixel run broken before its last result");

	// No request can be taken while the tile cache is still being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy)
		else $error("request possible during tile cache clear");

	// An unchanged result carries no color.
	a_unchanged_blank: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.changed |->
			result.last && (result.red == 8'd0) && (result.green == 8'd0) &&
			(result.blue == 8'd0))
		else $error("unchanged result with color or without last");

	// Requests are taken only from the idle state.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> state_q == ST_IDLE)
		else $error("request taken outside idle");

endmodule
